/* rtl/tclk_pkg.sv */
// Package for the tempo clock generator: shared types, register codes and
// the trigger division table. Used by tclk_core and the top level.
package tclk_pkg;

  // Configuration port widths and register codes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PULSE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIVISION = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIPLET  = 3'd3;

  // Register field widths and reset values
  localparam int unsigned PeriodW = 16;
  localparam int unsigned PulseW  = 12;
  localparam int unsigned DivIdxW = 4;
  localparam int unsigned DivW    = 9;
  localparam logic [PeriodW-1:0] PERIOD_RESET   = 16'd1000;
  localparam logic [PulseW-1:0]  PULSE_RESET    = 12'd48;
  localparam logic [DivIdxW-1:0] DIVISION_RESET = 4'd4;

  // Largest division count; the divider always stays below it
  localparam logic [DivW-1:0] DIV_MAX = 9'd384;

  // One sample tick request
  typedef struct packed {
    logic run;
    logic reset_button;
    logic sync_connected;
    logic sync_high;
  } tick_t;

  // Pulse levels of one result
  typedef struct packed {
    logic clock_out;
    logic reset_out;
    logic trigger_out;
  } pulses_t;

  // Configuration register set
  typedef struct packed {
    logic [PeriodW-1:0] period_ticks;
    logic [PulseW-1:0]  pulse_ticks;
    logic [DivIdxW-1:0] division_index;
    logic               triplet;
  } cfg_t;

  // Division count per index; indexes above eight act as eight
  function automatic logic [DivW-1:0] div_count(input logic [DivIdxW-1:0] idx,
                                                input logic trip);
    logic [DivW-1:0] n;
    n = 9'd2;
    case (idx)
      4'd0: n = 9'd384;
      4'd1: n = 9'd192;
      4'd2: n = 9'd96;
      4'd3: n = trip ? 9'd32 : 9'd48;
      4'd4: n = trip ? 9'd16 : 9'd24;
      4'd5: n = trip ? 9'd8  : 9'd12;
      4'd6: n = trip ? 9'd4  : 9'd6;
      4'd7: n = trip ? 9'd2  : 9'd3;
      default: n = trip ? 9'd1 : 9'd2;
    endcase
    return n;
  endfunction

endpackage

/* rtl/tclk_core.sv */
// Per-tick state of the tempo clock: edge detectors, timer, divider and the
// three pulse counters. Depends on tclk_pkg; driven by the top level.
module tclk_core import tclk_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16,
  parameter int unsigned PULSE_BITS = 12
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  tick_t   tick_i,
  input  cfg_t    cfg_i,
  output pulses_t pulses_o
);

  localparam int unsigned TW = (TIMER_BITS > PeriodW) ? TIMER_BITS : PeriodW;
  localparam int unsigned PW = (PULSE_BITS > PulseW) ? PULSE_BITS : PulseW;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [PW-1:0] PULSE_MAX_EXT = PW'({PULSE_BITS{1'b1}});

  logic                  run_prev_q, run_prev_d;
  logic                  button_prev_q, button_prev_d;
  logic                  sync_mode_prev_q, sync_mode_prev_d;
  logic                  sync_level_prev_q, sync_level_prev_d;
  logic [TIMER_BITS-1:0] tick_count_q, tick_count_d;
  logic [DivW-1:0]       divide_count_q, divide_count_d;
  logic [PULSE_BITS-1:0] clock_left_q, clock_left_d;
  logic [PULSE_BITS-1:0] reset_left_q, reset_left_d;
  logic [PULSE_BITS-1:0] trigger_left_q, trigger_left_d;

  logic [PW-1:0]         width_ext;
  logic [PULSE_BITS-1:0] width;
  logic                  run_rise, run_fall, button_rise, restart;
  logic [TIMER_BITS-1:0] tick_a, tick_b;
  logic [DivW-1:0]       div_a, div_b, div_n;
  logic [PULSE_BITS-1:0] clock_a, clock_b, reset_a, trigger_a, trigger_b;
  logic                  clock_ev, div_wrap;

  // Pulse width, saturated to the counter range
  assign width_ext = PW'(cfg_i.pulse_ticks);
  assign width     = (width_ext > PULSE_MAX_EXT) ? PULSE_BITS'(PULSE_MAX_EXT)
                                                 : PULSE_BITS'(width_ext);

  assign run_rise    = tick_i.run & ~run_prev_q;
  assign run_fall    = ~tick_i.run & run_prev_q;
  assign button_rise = tick_i.reset_button & ~button_prev_q;
  assign restart     = run_rise | button_rise;
  assign div_n       = div_count(cfg_i.division_index, cfg_i.triplet);

  // One tick of work: restart, timer or sync edge, divider, pulse counters
  always_comb begin
    reset_a   = (restart && width > reset_left_q) ? width : reset_left_q;
    clock_a   = run_fall ? '0 : clock_left_q;
    trigger_a = run_fall ? '0 : trigger_left_q;
    tick_a    = restart ? '0 : tick_count_q;
    div_a     = restart ? '0 : divide_count_q;

    // leaving sync mode restarts the internal timer
    if (!tick_i.sync_connected && sync_mode_prev_q) begin
      tick_a = '0;
    end

    clock_ev          = 1'b0;
    tick_b            = tick_a;
    sync_level_prev_d = sync_level_prev_q;
    if (tick_i.sync_connected) begin
      clock_ev          = tick_i.run & tick_i.sync_high & ~sync_level_prev_q;
      sync_level_prev_d = tick_i.sync_high;
    end else if (tick_i.run) begin
      if (tick_a != TIMER_MAX) begin
        tick_b = tick_a + 1'b1;
      end
      if (TW'(tick_b) >= TW'(cfg_i.period_ticks)) begin
        tick_b   = '0;
        clock_ev = 1'b1;
      end
    end

    // divider and clock pulse
    clock_b   = clock_a;
    trigger_b = trigger_a;
    div_b     = div_a;
    div_wrap  = 1'b0;
    if (clock_ev) begin
      if (width > clock_a) begin
        clock_b = width;
      end
      div_b = div_a + 1'b1;
      if (div_b >= div_n) begin
        div_b    = '0;
        div_wrap = 1'b1;
      end
    end
    if (div_wrap && width > trigger_a) begin
      trigger_b = width;
    end

    // pulse levels: high while the counter is nonzero, then count down
    pulses_o.clock_out   = (clock_b != '0);
    pulses_o.reset_out   = (reset_a != '0);
    pulses_o.trigger_out = (trigger_b != '0);
    clock_left_d   = clock_b - PULSE_BITS'(pulses_o.clock_out);
    reset_left_d   = reset_a - PULSE_BITS'(pulses_o.reset_out);
    trigger_left_d = trigger_b - PULSE_BITS'(pulses_o.trigger_out);

    tick_count_d     = tick_b;
    divide_count_d   = div_b;
    run_prev_d       = tick_i.run;
    button_prev_d    = tick_i.reset_button;
    sync_mode_prev_d = tick_i.sync_connected;
  end

  // State registers, updated once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_prev_q        <= 1'b0;
      button_prev_q     <= 1'b0;
      sync_mode_prev_q  <= 1'b0;
      sync_level_prev_q <= 1'b0;
      tick_count_q      <= '0;
      divide_count_q    <= '0;
      clock_left_q      <= '0;
      reset_left_q      <= '0;
      trigger_left_q    <= '0;
    end else if (step_i) begin
      run_prev_q        <= run_prev_d;
      button_prev_q     <= button_prev_d;
      sync_mode_prev_q  <= sync_mode_prev_d;
      sync_level_prev_q <= sync_level_prev_d;
      tick_count_q      <= tick_count_d;
      divide_count_q    <= divide_count_d;
      clock_left_q      <= clock_left_d;
      reset_left_q      <= reset_left_d;
      trigger_left_q    <= trigger_left_d;
    end
  end

  // Divider never reaches the largest table count
  assert property (@(posedge clk_i) disable iff (!rst_ni) divide_count_q < DIV_MAX)
    else $error("divider out of range");

  // Run falling cancels clock and trigger pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !tick_i.run && run_prev_q |=> clock_left_q == '0 && trigger_left_q == '0)
    else $error("pulses not cancelled on stop");

  // A restart by a run rise leaves the timer and divider at most one step from zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tick_i.run && !run_prev_q |=> tick_count_q <= TIMER_BITS'(1) &&
    divide_count_q <= DivW'(1))
    else $error("restart did not clear timer and divider");

endmodule

/* rtl/tempo_clock_with_sync_and_divider.sv */
// Tempo clock generator top level: handshakes, configuration registers,
// input and result registers. Depends on tclk_pkg and tclk_core.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   in       | sink      | in_valid_i/in_ready_o | run, reset_button, sync_*
//   out      | source    | out_valid_o/out_ready_i | clock_out, reset_out, trigger_out
//   cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick request per cycle sustained while the output is not stalled; a result
// passes the input register, then the tick logic and the result register.
// Reset clears all tick state and loads the default register values.
// A stalled result holds; the input register still takes one more request,
// and only then does in_ready_o drop. cfg_ready_o is always high.
module tempo_clock_with_sync_and_divider import tclk_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16,
  parameter int unsigned PULSE_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                run_i,
  input  logic                reset_button_i,
  input  logic                sync_connected_i,
  input  logic                sync_high_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                clock_out_o,
  output logic                reset_out_o,
  output logic                trigger_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    in_valid_q;
  tick_t   tick_q;
  logic    out_valid_q;
  pulses_t pulses_q, pulses_d;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  // Configuration register decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks   <= PERIOD_RESET;
      cfg_q.pulse_ticks    <= PULSE_RESET;
      cfg_q.division_index <= DIVISION_RESET;
      cfg_q.triplet        <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD:   cfg_q.period_ticks   <= cfg_data_i;
        CFG_PULSE:    cfg_q.pulse_ticks    <= cfg_data_i[PulseW-1:0];
        CFG_DIVISION: cfg_q.division_index <= cfg_data_i[DivIdxW-1:0];
        CFG_TRIPLET:  cfg_q.triplet        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a tick moves on when the result register is free
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (~out_valid_q | out_ready_i) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q.run            <= run_i;
      tick_q.reset_button   <= reset_button_i;
      tick_q.sync_connected <= sync_connected_i;
      tick_q.sync_high      <= sync_high_i;
    end
    if (advance) begin
      pulses_q <= pulses_d;
    end
  end

  tclk_core #(
    .TIMER_BITS(TIMER_BITS),
    .PULSE_BITS(PULSE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .tick_i  (tick_q),
    .cfg_i   (cfg_q),
    .pulses_o(pulses_d)
  );

  assign out_valid_o   = out_valid_q;
  assign clock_out_o   = pulses_q.clock_out;
  assign reset_out_o   = pulses_q.reset_out;
  assign trigger_out_o = pulses_q.trigger_out;

endmodule
